// ----- rtl/clws_pkg.sv -----
// ============================================================================
// clws_pkg
// Types and constants shared by the character LCD write sequencer.
// ============================================================================
package clws_pkg;

    // Operation codes of a request
    localparam logic [2:0] OP_COMMAND  = 3'd0;
    localparam logic [2:0] OP_DATA     = 3'd1;
    localparam logic [2:0] OP_INIT     = 3'd2;
    localparam logic [2:0] OP_POSITION = 3'd3;
    localparam logic [2:0] OP_NUMBER   = 3'd4;
    localparam logic [2:0] OP_GLYPH    = 3'd5;

    // Register-select values
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    // Controller command bytes and offsets
    localparam logic [7:0] CMD_FUNCTION_SET = 8'b0011_1000;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'b0000_1100;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_DDRAM_BASE   = 8'd128;
    localparam logic [7:0] LINE1_OFFSET     = 8'h40;
    localparam logic [7:0] CMD_CGRAM_BASE   = 8'd64;
    localparam logic [7:0] ASCII_ZERO       = 8'd48;

    // Step counter of the fixed-length runs (longest run is 11 writes)
    localparam int STEP_W = 4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  byte_value;
        logic        row;
        logic [5:0]  column;
        logic [31:0] number;
        logic [63:0] glyph_rows;
        logic [2:0]  glyph_slot;
    } t_request;

    typedef struct packed {
        logic       register_select;
        logic [7:0] bus_byte;
        logic       last_of_run;
    } t_result;

    // DDRAM address command for a row and column
    function automatic logic [7:0] position_command(input logic row, input logic [5:0] column);
        logic [7:0] addr;
        addr = CMD_DDRAM_BASE + {2'b00, column};
        if (row) begin
            addr = addr + LINE1_OFFSET;
        end
        return addr;
    endfunction

    // Index of the final step of a fixed-length run
    function automatic logic [STEP_W-1:0] final_step(input logic [2:0] op);
        logic [STEP_W-1:0] s;
        unique case (op)
            OP_INIT:  s = STEP_W'(2);
            OP_GLYPH: s = STEP_W'(10);
            default:  s = '0;
        endcase
        return s;
    endfunction

    // Write issued at a given step of a fixed-length run
    function automatic t_result fixed_write(input t_request req, input logic [STEP_W-1:0] step);
        t_result w;
        w.register_select = RS_COMMAND;
        w.bus_byte        = '0;
        w.last_of_run     = (step == final_step(req.operation));
        unique case (req.operation)
            OP_COMMAND: begin
                w.bus_byte = req.byte_value;
            end
            OP_DATA: begin
                w.register_select = RS_DATA;
                w.bus_byte        = req.byte_value;
            end
            OP_INIT: begin
                unique case (step)
                    STEP_W'(0): w.bus_byte = CMD_FUNCTION_SET;
                    STEP_W'(1): w.bus_byte = CMD_DISPLAY_ON;
                    default:    w.bus_byte = CMD_CLEAR;
                endcase
            end
            OP_POSITION: begin
                w.bus_byte = position_command(req.row, req.column);
            end
            OP_GLYPH: begin
                unique case (step)
                    STEP_W'(0): w.bus_byte = CMD_CGRAM_BASE + {2'b00, req.glyph_slot, 3'b000};
                    STEP_W'(1), STEP_W'(2), STEP_W'(3), STEP_W'(4),
                    STEP_W'(5), STEP_W'(6), STEP_W'(7), STEP_W'(8): begin
                        w.register_select = RS_DATA;
                        w.bus_byte = req.glyph_rows[8*(3'(step - STEP_W'(1))) +: 8];
                    end
                    STEP_W'(9): w.bus_byte = position_command(req.row, req.column);
                    default: begin
                        w.register_select = RS_DATA;
                        w.bus_byte        = {5'b00000, req.glyph_slot};
                    end
                endcase
            end
            default: begin
                w.bus_byte = '0;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/char_lcd_write_sequencer_top.sv -----
// ============================================================================
// char_lcd_write_sequencer_top
// Expands character LCD requests into runs of controller bus writes.
// ============================================================================
//
//  channel  | signals                     | handshake
//  ---------+-----------------------------+----------------------------------
//  request  | i_request (t_request)       | taken when i_start && !o_busy
//  write    | o_result  (t_result)        | valid for one cycle at o_strobe
//
//  Fixed runs (command, data, position 1, init 3, glyph 11 writes) issue one
//  write per cycle from the S_FIXED state entered on acceptance; o_busy is high
//  through the whole run, and a new request is taken once it drops.
//  A number runs the shift-and-add-3 converter for min(NUMBER_WIDTH, 32) steps,
//  then walks every digit of the converter, dropping leading zeros.
//  Synchronous active-low reset returns to idle; unused codes are taken with
//  no writes; the receiver cannot stall, and o_busy drops with the final write.
// ============================================================================
module char_lcd_write_sequencer_top
    import clws_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_request i_request,
    output logic     o_busy,
    output logic     o_strobe,
    output t_result  o_result
);

    localparam int NW    = (NUMBER_WIDTH < 32) ? NUMBER_WIDTH : 32;
    localparam int NDIG  = (NW * 1233) / 4096 + 1;
    localparam int DIG_W = $clog2(NDIG);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIXED,
        S_CONVERT,
        S_DIGITS
    } t_state;

    t_state            r_state;
    t_request          r_req;
    logic [STEP_W-1:0] r_step;
    logic [DIG_W-1:0]  r_digit;
    logic              r_seen;
    logic              r_strobe;
    t_result           r_result;

    logic              w_accept;
    logic              w_conv_start;
    logic              w_conv_done;
    logic [4*NDIG-1:0] w_bcd;
    logic [3:0]        w_cur_digit;
    t_result           w_fixed;

    assign w_accept     = i_start && (r_state == S_IDLE);
    assign w_conv_start = w_accept && (i_request.operation == OP_NUMBER);
    assign w_cur_digit  = w_bcd[4*r_digit +: 4];
    assign w_fixed      = fixed_write(r_req, r_step);

    clws_bcd_conv #(
        .NW   (NW),
        .NDIG (NDIG)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_conv_start),
        .i_value (i_request.number[NW-1:0]),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    // Hold the request fields used by the fixed-length runs
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_request;
        end
    end

    // Sequence the runs and register each write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_digit  <= '0;
            r_seen   <= 1'b0;
            r_strobe <= 1'b0;
            r_result <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_step <= '0;
                        unique case (i_request.operation)
                            OP_COMMAND, OP_DATA, OP_INIT, OP_POSITION, OP_GLYPH: begin
                                r_state <= S_FIXED;
                            end
                            OP_NUMBER: begin
                                r_state <= S_CONVERT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_FIXED: begin
                    r_strobe <= 1'b1;
                    r_result <= w_fixed;
                    r_step   <= r_step + STEP_W'(1);
                    if (w_fixed.last_of_run) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CONVERT: begin
                    r_digit <= DIG_W'(NDIG - 1);
                    r_seen  <= 1'b0;
                    if (w_conv_done) begin
                        r_state <= S_DIGITS;
                    end
                end
                S_DIGITS: begin
                    // Drop leading zeros, but always emit the units digit
                    if (r_seen || (w_cur_digit != 4'd0) || (r_digit == '0)) begin
                        r_strobe                 <= 1'b1;
                        r_result.register_select <= RS_DATA;
                        r_result.bus_byte        <= ASCII_ZERO + {4'b0000, w_cur_digit};
                        r_result.last_of_run     <= (r_digit == '0);
                        r_seen                   <= 1'b1;
                    end
                    r_digit <= r_digit - DIG_W'(1);
                    if (r_digit == '0) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- rtl/clws_bcd_conv.sv -----
// ============================================================================
// clws_bcd_conv
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
// ============================================================================
module clws_bcd_conv
    import clws_pkg::*;
#(
    parameter int NW   = 32,
    parameter int NDIG = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NW-1:0]     i_value,
    output logic              o_done,
    output logic [4*NDIG-1:0] o_bcd
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]     r_bin;
    logic [4*NDIG-1:0] r_bcd;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [4*NDIG-1:0] n_adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                n_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                n_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NW);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    // Shift one binary bit into the BCD digits per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_cnt != '0) begin
            r_bin <= {r_bin[NW-2:0], 1'b0};
            r_bcd <= {n_adj[4*NDIG-2:0], r_bin[NW-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ----- rtl/clws_checker.sv -----
// ============================================================================
// clws_checker
// Port-level checks on request acceptance and write runs.
// ============================================================================
module clws_checker
    import clws_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_start,
    input t_request i_request,
    input logic     o_busy,
    input logic     o_strobe,
    input t_result  o_result
);

    // Final write of a run frees the sequencer
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_of_run) |-> !o_busy)
        else $error("final write issued while still busy");

    // A write that is not final keeps the sequencer busy
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_of_run) |-> o_busy)
        else $error("run ended without a final write");

    // Writes of one run follow each other without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_of_run) |=> o_strobe)
        else $error("gap inside a write run");

    // A valid request makes the sequencer busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_request.operation <= OP_GLYPH)) |=> o_busy)
        else $error("request taken but sequencer not busy");

endmodule

bind char_lcd_write_sequencer_top clws_checker u_clws_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .i_request (i_request),
    .o_busy    (o_busy),
    .o_strobe  (o_strobe),
    .o_result  (o_result)
);
